>>> src/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, the scan word that walks the cell chain, the update word
// that is broadcast to all cells, and the control state encoding.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAME_COUNT = 4;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int RANK_W      = SLOT_W;
    localparam int FIU_W       = 3;
    localparam int FAULT_W     = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [FIU_W-1:0]  FIU_RESET   = 3'd3;
    localparam logic [ADDR_W-1:0] ADDR_FRAMES = 3'd0;

    // Search word handed from cell to cell
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [SLOT_W-1:0]    hit_slot;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty;
        logic [SLOT_W-1:0]    empty_slot;
        logic                 max_any;
        logic [SLOT_W-1:0]    max_slot;
        logic [RANK_W-1:0]    max_rank;
        logic [PAGE_BITS-1:0] max_page;
    } t_scan;

    // Update word broadcast to every cell at the end of a search
    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        logic                 fill;
        logic                 age_all;
        logic [RANK_W-1:0]    old_rank;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

>>> src/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement top level
// A start is taken only while idle. The search word walks the frame cell
// chain one cell per cycle, registered in each cell and once more for o_valid;
// busy covers that walk, so no new word is taken until the last is through.
// The receiver cannot stall; each result is shown for one cycle on o_valid.
// Reset (synchronous, active low) empties all frames, clears ranks and the
// fault count, and sets frames_in_use to 3.
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [lru_pkg::PAGE_BITS-1:0]  i_page_number,
    // result channel
    output logic                           o_valid,
    output logic                           o_hit,
    output logic [lru_pkg::SLOT_W-1:0]     o_frame_slot,
    output logic                           o_evicted_valid,
    output logic [lru_pkg::PAGE_BITS-1:0]  o_evicted_page,
    output logic [lru_pkg::FAULT_W-1:0]    o_fault_total,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lru_pkg::ADDR_W-1:0]     paddr,
    input  logic [lru_pkg::DATA_W-1:0]     pwdata,
    output logic [lru_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    lru_pkg::t_state                r_state;
    lru_pkg::t_state                n_state;
    logic [lru_pkg::FIU_W-1:0]      r_fiu;
    logic [lru_pkg::FAULT_W-1:0]    r_fault;
    logic [lru_pkg::FAULT_W-1:0]    n_fault;
    logic                           r_valid;
    logic                           r_hit;
    logic [lru_pkg::SLOT_W-1:0]     r_slot;
    logic                           r_evict;
    logic [lru_pkg::PAGE_BITS-1:0]  r_evict_page;

    logic                           w_accept;
    logic                           w_done;
    logic [lru_pkg::FRAME_COUNT-1:0] w_active;
    logic                           w_vld  [lru_pkg::FRAME_COUNT+1];
    lru_pkg::t_scan                 w_word [lru_pkg::FRAME_COUNT+1];
    lru_pkg::t_scan                 w_seed;
    lru_pkg::t_scan                 w_last;
    lru_pkg::t_upd                  w_upd;

    assign w_accept = start && (r_state == lru_pkg::ST_IDLE);
    assign busy     = (r_state != lru_pkg::ST_IDLE);
    assign w_done   = w_vld[lru_pkg::FRAME_COUNT];
    assign w_last   = w_word[lru_pkg::FRAME_COUNT];

    // Seed the search word at the head of the chain
    always_comb begin
        w_seed      = '0;
        w_seed.page = i_page_number;
    end

    assign w_vld[0]  = w_accept;
    assign w_word[0] = w_seed;

    // Row of frame cells; frame zero always takes part
    for (genvar gi = 0; gi < lru_pkg::FRAME_COUNT; gi++) begin : g_cell
        assign w_active[gi] = (gi == 0) || (int'(r_fiu) > gi);

        lru_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (lru_pkg::SLOT_W'(gi)),
            .i_active (w_active[gi]),
            .i_vld    (w_vld[gi]),
            .i_word   (w_word[gi]),
            .i_upd    (w_upd),
            .o_vld    (w_vld[gi+1]),
            .o_word   (w_word[gi+1])
        );
    end

    // Pick hit, empty frame or victim from the finished search word
    always_comb begin
        w_upd      = '0;
        w_upd.en   = w_done;
        w_upd.page = w_last.page;
        if (w_last.hit) begin
            w_upd.slot     = w_last.hit_slot;
            w_upd.old_rank = w_last.hit_rank;
        end else if (w_last.empty) begin
            w_upd.slot    = w_last.empty_slot;
            w_upd.fill    = 1'b1;
            w_upd.age_all = 1'b1;
        end else begin
            w_upd.slot     = w_last.max_slot;
            w_upd.fill     = 1'b1;
            w_upd.old_rank = w_last.max_rank;
        end
    end

    // Saturating fault count
    always_comb begin
        n_fault = r_fault;
        if (w_done && !w_last.hit && (r_fault != '1)) begin
            n_fault = r_fault + 1'b1;
        end
    end

    // Sequence: idle until start, then wait for the chain to finish
    always_comb begin
        n_state = r_state;
        case (r_state)
            lru_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN: begin
                if (w_done) begin
                    n_state = lru_pkg::ST_IDLE;
                end
            end
            default: n_state = lru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lru_pkg::ST_IDLE;
            r_fault <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fault <= n_fault;
            r_valid <= w_done;
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_hit        <= w_last.hit;
            r_slot       <= w_upd.slot;
            r_evict      <= !w_last.hit && !w_last.empty;
            r_evict_page <= (!w_last.hit && !w_last.empty) ? w_last.max_page : '0;
        end
    end

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu <= lru_pkg::FIU_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == lru_pkg::ADDR_FRAMES)) begin
            r_fiu <= pwdata[lru_pkg::FIU_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == lru_pkg::ADDR_FRAMES) ?
                    {{(lru_pkg::DATA_W-lru_pkg::FIU_W){1'b0}}, r_fiu} : '0;

    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_evict;
    assign o_evicted_page  = r_evict_page;
    assign o_fault_total   = r_fault;

endmodule

>>> src/lru_cell.sv
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (page, full flag, recency rank). Folds its frame into the
// search word from its left neighbor and registers it for the right one;
// applies the broadcast update word to its own frame.
// ----------------------------------------------------------------------------
module lru_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lru_pkg::SLOT_W-1:0]   i_idx,
    input  logic                         i_active,
    input  logic                         i_vld,
    input  lru_pkg::t_scan               i_word,
    input  lru_pkg::t_upd                i_upd,
    output logic                         o_vld,
    output lru_pkg::t_scan               o_word
);

    logic                          r_full;
    logic [lru_pkg::RANK_W-1:0]    r_rank;
    logic [lru_pkg::PAGE_BITS-1:0] r_page;
    logic                          r_vld;
    lru_pkg::t_scan                r_word;
    lru_pkg::t_scan                n_word;
    logic                          w_match;

    // Fold this frame into the search word
    always_comb begin
        w_match = i_active && r_full && (r_page == i_word.page);
        n_word  = i_word;
        if (!i_word.hit && w_match) begin
            n_word.hit      = 1'b1;
            n_word.hit_slot = i_idx;
            n_word.hit_rank = r_rank;
        end
        if (i_active && !r_full && !i_word.empty) begin
            n_word.empty      = 1'b1;
            n_word.empty_slot = i_idx;
        end
        // Largest rank wins, earlier frame keeps a tie
        if (i_active && (!i_word.max_any || (r_rank > i_word.max_rank))) begin
            n_word.max_any  = 1'b1;
            n_word.max_slot = i_idx;
            n_word.max_rank = r_rank;
            n_word.max_page = r_page;
        end
    end

    // Hand the word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Apply the update: touch the chosen frame, age the more recent ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_rank <= '0;
        end else if (i_upd.en) begin
            if (i_upd.slot == i_idx) begin
                r_rank <= '0;
                if (i_upd.fill) begin
                    r_full <= 1'b1;
                end
            end else if (r_full && (i_upd.age_all || (r_rank < i_upd.old_rank))) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    // Load the new page on a fill
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.fill && (i_upd.slot == i_idx)) begin
            r_page <= i_upd.page;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Feeds page references through the start/busy command port and predicts each
// lookup with an in-bench LRU frame table: hit search, lowest empty fill,
// least-recent eviction, rank aging and the saturating fault count. Every
// strobed result is checked field by field against the oldest prediction.
// The frames_in_use register is rewritten between phases over the APB port
// and read back.
// ----------------------------------------------------------------------------
module tb;
    import lru_pkg::*;

    localparam int                CLK_HALF    = 5;
    localparam int                CYCLE_LIMIT = 200000;
    localparam int                PHASE_REFS  = 80;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [FAULT_W-1:0]   faults;
    } lookup_t;

    // DUT ports
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [PAGE_BITS-1:0]  i_page_number   = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic [SLOT_W-1:0]     o_frame_slot;
    logic                  o_evicted_valid;
    logic [PAGE_BITS-1:0]  o_evicted_page;
    logic [FAULT_W-1:0]    o_fault_total;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [ADDR_W-1:0]     paddr           = '0;
    logic [DATA_W-1:0]     pwdata          = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Frame table mirror
    logic [PAGE_BITS-1:0]  frame_page [FRAME_COUNT];
    logic                  frame_full [FRAME_COUNT];
    logic [RANK_W-1:0]     frame_rank [FRAME_COUNT];
    logic [FAULT_W-1:0]    fault_count = '0;
    logic [FIU_W-1:0]      frames_cfg  = FIU_RESET;

    logic [PAGE_BITS-1:0]  pending_refs [$];
    lookup_t               predicted_lookups [$];
    int                    refs_queued = 0;
    int                    refs_taken  = 0;
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    idle_left   = 0;
    logic                  idle_mode   = 1'b1;

    lru_page_replacement_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
            frame_page[i] = '0;
            frame_full[i] = 1'b0;
            frame_rank[i] = '0;
        end
    end

    // Predict one lookup and advance the frame table
    task automatic lru_predict(input logic [PAGE_BITS-1:0] pg);
        int      n;
        int      slot;
        int      old_rank;
        logic    is_hit;
        logic    found;
        lookup_t res;
        n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAME_COUNT) ? FRAME_COUNT : int'(frames_cfg));
        slot = 0;
        is_hit = 1'b0;
        found = 1'b0;
        res = '0;
        for (int i = 0; i < n; i++) begin
            if (!is_hit && frame_full[i] && frame_page[i] == pg) begin
                is_hit = 1'b1;
                slot = i;
            end
        end
        if (!is_hit) begin
            for (int i = 0; i < n; i++) begin
                if (!found && !frame_full[i]) begin
                    found = 1'b1;
                    slot = i;
                end
            end
            // No empty frame: evict the largest rank, lowest index on a tie
            if (!found) begin
                slot = 0;
                for (int i = 1; i < n; i++) begin
                    if (frame_rank[i] > frame_rank[slot])
                        slot = i;
                end
                res.ev_valid = 1'b1;
                res.ev_page = frame_page[slot];
            end
        end
        // Age every full frame more recent than the touched one
        old_rank = frame_full[slot] ? int'(frame_rank[slot]) : FRAME_COUNT;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (i != slot && frame_full[i] && int'(frame_rank[i]) < old_rank)
                frame_rank[i] = frame_rank[i] + 1'b1;
        end
        frame_rank[slot] = '0;
        if (!is_hit) begin
            frame_page[slot] = pg;
            frame_full[slot] = 1'b1;
            if (fault_count != '1)
                fault_count = fault_count + 1'b1;
        end
        res.hit = is_hit;
        res.slot = SLOT_W'(slot);
        res.faults = fault_count;
        predicted_lookups.push_back(res);
        refs_taken++;
    endtask

    task automatic queue_ref(input logic [PAGE_BITS-1:0] pg);
        pending_refs.push_back(pg);
        refs_queued++;
    endtask

    // Hold until every queued word is taken and every result has come back
    task automatic wait_drained();
        while (refs_taken != refs_queued || predicted_lookups.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_FRAMES)
            frames_cfg = val[FIU_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_readback();
        logic [DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FRAMES;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(frames_cfg)) begin
            if (error_count < 10)
                $display("frames_in_use readback: expected %0d, got %h", frames_cfg, got);
            error_count++;
        end
    endtask

    // Driver: present the next word, hold it while busy, insert idle bursts
    always @(posedge i_clk) begin : drive_refs
        logic                 next_start;
        logic [PAGE_BITS-1:0] next_page;
        next_start = start;
        next_page  = i_page_number;
        if (!i_rst_n) begin
            next_start = 1'b0;
            idle_left  = 0;
        end else begin
            if (start && !busy) begin
                lru_predict(i_page_number);
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left != 0) begin
                    idle_left--;
                end else if (pending_refs.size() != 0) begin
                    if (idle_mode && $urandom_range(0, 3) == 0) begin
                        idle_left = $urandom_range(0, 12);
                    end else begin
                        next_page  = pending_refs.pop_front();
                        next_start = 1'b1;
                    end
                end
            end
        end
        start         <= next_start;
        i_page_number <= next_page;
    end

    // Monitor: compare each strobed word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        lookup_t want;
        if (i_rst_n && o_valid) begin
            if (predicted_lookups.size() == 0) begin
                if (error_count < 10)
                    $display("result with no lookup pending: hit=%b slot=%0d ev=%b/%h faults=%0d",
                             o_hit, o_frame_slot, o_evicted_valid, o_evicted_page,
                             o_fault_total);
                error_count++;
            end else begin
                want = predicted_lookups.pop_front();
                if (o_hit !== want.hit || o_frame_slot !== want.slot ||
                    o_evicted_valid !== want.ev_valid || o_evicted_page !== want.ev_page ||
                    o_fault_total !== want.faults) begin
                    if (error_count < 10)
                        $display({"lookup mismatch: expected hit=%b slot=%0d ev=%b/%h ",
                                  "faults=%0d, got hit=%b slot=%0d ev=%b/%h faults=%0d"},
                                 want.hit, want.slot, want.ev_valid, want.ev_page,
                                 want.faults, o_hit, o_frame_slot, o_evicted_valid,
                                 o_evicted_page, o_fault_total);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        int                   frame_settings [8];
        logic [PAGE_BITS-1:0] pool [6];
        int                   remaining;
        int                   chunk;
        frame_settings = '{7, 1, 0, 4, 2, 6, 3, 5};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_readback();

        // Reset setting of three frames: fills, hits, two evictions
        idle_mode = 1'b1;
        queue_ref(16'h0000);
        queue_ref(16'hFFFF);
        queue_ref(16'h0000);
        queue_ref(16'h5555);
        queue_ref(16'hAAAA);
        queue_ref(16'hFFFF);
        queue_ref(16'h5555);
        wait_drained();

        // Above the frame count: saturate to four frames
        cfg_write(ADDR_FRAMES, 32'hFFFF_FFF8 | 32'd7);
        cfg_readback();
        queue_ref(16'h1234);
        queue_ref(16'h0000);
        queue_ref(16'h1234);
        wait_drained();

        // Zero frames behaves as one; frames above it keep their pages
        cfg_write(ADDR_FRAMES, 32'd0);
        cfg_readback();
        queue_ref(16'hFFFF);
        queue_ref(16'hFFFF);
        queue_ref(16'h0F0F);
        wait_drained();

        // Back to four: the inactive frames come back resident
        cfg_write(ADDR_FRAMES, 32'd4);
        cfg_readback();
        queue_ref(16'h1234);
        queue_ref(16'hAAAA);
        queue_ref(16'hF0F0);
        wait_drained();

        cfg_write(ADDR_FRAMES, 32'd1);
        cfg_readback();
        queue_ref(16'h8001);
        queue_ref(16'h8001);
        wait_drained();

        // Write to an unmapped register must not disturb frames_in_use
        cfg_write(ADDR_UNUSED, 32'd3);
        cfg_write(ADDR_FRAMES, 32'd2);
        cfg_readback();
        queue_ref(16'h7FFE);
        queue_ref(16'h8001);
        queue_ref(16'h0001);
        queue_ref(16'h7FFE);
        wait_drained();

        // Random phases: mostly a small page pool for hits and evictions
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(ADDR_FRAMES, ($urandom & ~32'h7) | frame_settings[ph]);
            cfg_readback();
            for (int i = 0; i < 6; i++)
                pool[i] = $urandom_range(0, 65535);
            remaining = PHASE_REFS;
            while (remaining > 0) begin
                chunk = $urandom_range(10, 40);
                if (chunk > remaining)
                    chunk = remaining;
                idle_mode = (ph == 7) ? 1'b0 : 1'($urandom_range(0, 1));
                for (int k = 0; k < chunk; k++) begin
                    if ($urandom_range(0, 3) != 0)
                        queue_ref(pool[$urandom_range(0, 5)]);
                    else
                        queue_ref($urandom_range(0, 65535));
                end
                remaining -= chunk;
                // Sometimes let the pipe empty before the next burst
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (FRAME_COUNT + 4) @(posedge i_clk);
        if (error_count == 0 && predicted_lookups.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
